[rtl/u32f_pkg.sv]
// Package for the decimal ASCII formatter: FSM state type, command/status
// structs and fixed constants. No dependencies.
package u32f_pkg;

  localparam int unsigned DIGITS_MAX = 10;
  localparam int unsigned DIG_IDX_W  = 4;
  localparam logic [7:0]  ASCII_ZERO = 8'h30;
  localparam logic [31:0] RECIP_TEN  = 32'hCCCC_CCCD;
  localparam int unsigned RECIP_SHIFT = 35;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } fsm_state_t;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic conv_done;
    logic out_free;
    logic item_last;
  } dp_sts_t;

endpackage

[rtl/u32f_ctrl.sv]
// Controller FSM for the decimal ASCII formatter.
// Depends on u32f_pkg; drives the datapath by command, reads its status.
module u32f_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  u32f_pkg::dp_sts_t  sts,
  output u32f_pkg::ctl_cmd_t cmd
);
  import u32f_pkg::*;

  fsm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (sts.conv_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free && sts.item_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready     = 1'b0;
    cmd.load      = 1'b0;
    cmd.conv_step = 1'b0;
    cmd.emit      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_CONV: begin
        cmd.conv_step = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = sts.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

endmodule

[rtl/u32f_dpath.sv]
// Datapath for the decimal ASCII formatter: reciprocal divide-by-ten digit
// extraction, digit store, character sequencing and output register.
// Depends on u32f_pkg; commanded by u32f_ctrl.
module u32f_dpath #(
  parameter int unsigned MAX_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [31:0]        value,
  input  logic [4:0]         field_width,
  input  logic               align_left,
  input  u32f_pkg::ctl_cmd_t cmd,
  output u32f_pkg::dp_sts_t  sts,
  input  logic               out_tready,
  output logic               out_tvalid,
  output logic [7:0]         char_code,
  output logic               char_valid,
  output logic [3:0]         position,
  output logic [4:0]         returned_length,
  output logic               fits,
  output logic               last
);
  import u32f_pkg::*;

  localparam logic [4:0] WIDTH_CLAMP = (MAX_WIDTH > 31) ? 5'd31 : 5'(MAX_WIDTH);

  logic [31:0]          v_r, v_nxt;
  logic [4:0]           width_r, width_nxt;
  logic                 left_r, left_nxt;
  logic [DIG_IDX_W-1:0] k_r, k_nxt;
  logic [3:0]           dig_r [DIGITS_MAX];
  logic [4:0]           len_r, len_nxt;
  logic                 fit_r, fit_nxt;
  logic [4:0]           place_r, place_nxt;
  logic [4:0]           pos_r, pos_nxt;

  logic                 ovalid_r, ovalid_nxt;
  logic [7:0]           ochar_r;
  logic                 ocv_r;
  logic [3:0]           opos_r;
  logic [4:0]           olen_r;
  logic                 ofit_r;
  logic                 olast_r;

  logic [63:0]          prod;
  logic [31:0]          quot;
  logic [31:0]          rem;
  logic [4:0]           count;
  logic [4:0]           total;
  logic [3:0]           dsel;

  assign prod  = {32'd0, v_r} * {32'd0, RECIP_TEN};
  assign quot  = {3'd0, prod[63:RECIP_SHIFT]};
  assign rem   = v_r - ((quot << 3) + (quot << 1));
  assign count = {1'b0, k_r} + 5'd1;
  assign total = left_r ? count : width_r;
  assign dsel  = (place_r < {1'b0, k_r}) ? dig_r[place_r[DIG_IDX_W-1:0]] : 4'd0;

  assign sts = '{conv_done: (quot == 32'd0),
                 out_free:  (!ovalid_r || out_tready),
                 item_last: (!fit_r || (place_r == 5'd0))};

  always_comb begin
    v_nxt      = v_r;
    width_nxt  = width_r;
    left_nxt   = left_r;
    k_nxt      = k_r;
    len_nxt    = len_r;
    fit_nxt    = fit_r;
    place_nxt  = place_r;
    pos_nxt    = pos_r;
    if (cmd.load) begin
      v_nxt     = value;
      width_nxt = (field_width > WIDTH_CLAMP) ? WIDTH_CLAMP : field_width;
      left_nxt  = align_left;
      k_nxt     = '0;
    end else if (cmd.conv_step) begin
      v_nxt = quot;
      k_nxt = k_r + 1'b1;
      if (quot == 32'd0) begin
        len_nxt   = total;
        fit_nxt   = (width_r != 5'd0) && (count <= width_r);
        place_nxt = total - 5'd1;
        pos_nxt   = '0;
      end
    end else if (cmd.emit) begin
      place_nxt = place_r - 5'd1;
      pos_nxt   = pos_r + 5'd1;
    end
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (cmd.emit) begin
      ovalid_nxt = 1'b1;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r     <= v_nxt;
    width_r <= width_nxt;
    left_r  <= left_nxt;
    k_r     <= k_nxt;
    len_r   <= len_nxt;
    fit_r   <= fit_nxt;
    place_r <= place_nxt;
    pos_r   <= pos_nxt;
    if (cmd.conv_step) begin
      dig_r[k_r] <= rem[3:0];
    end
    if (cmd.emit) begin
      ochar_r <= fit_r ? (ASCII_ZERO + {4'd0, dsel}) : 8'd0;
      ocv_r   <= fit_r;
      opos_r  <= fit_r ? pos_r[3:0] : 4'd0;
      olen_r  <= len_r;
      ofit_r  <= fit_r;
      olast_r <= !fit_r || (place_r == 5'd0);
    end
  end

  assign out_tvalid      = ovalid_r;
  assign char_code       = ochar_r;
  assign char_valid      = ocv_r;
  assign position        = opos_r;
  assign returned_length = olen_r;
  assign fits            = ofit_r;
  assign last            = olast_r;

endmodule

[rtl/uint32_decimal_ascii_formatter.sv]
// Top level of the decimal ASCII formatter: stream ports, packing, and the
// controller/datapath pair. Depends on u32f_pkg, u32f_ctrl, u32f_dpath.
//
//   channel  dir  tdata                                   tuser          tlast
//   in_      in   value[31:0] field_width[36:32]          align_left[0]  -
//   out_     out  char_code[7:0] position[11:8] len[16:12] char_valid[0]  last
//                                                          fits[1]
//
// Each item is accepted, then its decimal digits (1 to 10) are extracted one
// by one through the reciprocal divide-by-ten unit, then its result characters
// (1 to the field width) are sent one by one through the output register.
// Reset is synchronous, active low; it clears the FSM and the output valid.
// A stalled out_tready holds the output register; the next item is taken once
// the final result of the current one sits in that register.
module uint32_decimal_ascii_formatter #(
  parameter int unsigned MAX_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // value[31:0], field_width[36:32], zero pad
  input  logic [0:0]  in_tuser,   // align_left[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // char_code[7:0], position[11:8],
                                  // returned_length[16:12], zero pad
  output logic [1:0]  out_tuser,  // char_valid[0], fits[1]
  output logic        out_tlast
);
  import u32f_pkg::*;

  ctl_cmd_t    cmd;
  dp_sts_t     sts;
  logic [7:0]  char_code;
  logic        char_valid;
  logic [3:0]  position;
  logic [4:0]  returned_length;
  logic        fits;

  u32f_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  u32f_dpath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .value           (in_tdata[31:0]),
    .field_width     (in_tdata[36:32]),
    .align_left      (in_tuser[0]),
    .cmd             (cmd),
    .sts             (sts),
    .out_tready      (out_tready),
    .out_tvalid      (out_tvalid),
    .char_code       (char_code),
    .char_valid      (char_valid),
    .position        (position),
    .returned_length (returned_length),
    .fits            (fits),
    .last            (out_tlast)
  );

  assign out_tdata = {7'd0, returned_length, position, char_code};
  assign out_tuser = {fits, char_valid};

endmodule

[rtl/u32f_checker.sv]
// Port-level checks for the decimal ASCII formatter, bound to the top level.
// Depends only on the top-level ports.
module u32f_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("output transaction changed while stalled");

  a_nofit_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tlast && !out_tuser[1]
      && (out_tdata[11:0] == 12'd0))
    else $error("no-character result is not a lone final transaction");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> (out_tdata[7:4] == 4'h3)
      && (out_tdata[3:0] <= 4'd9) && out_tuser[1])
    else $error("character result is not an ASCII digit");

  a_no_accept_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input accepted before final result was produced");

endmodule

bind uint32_decimal_ascii_formatter u32f_checker u_chk (.*);
